>>> hdl/imf_pkg.sv
// Shared types, field layout and constants of the Ising Metropolis flip engine.
package imf_pkg;

	// Lattice side by default
	localparam int SIDE_DEF = 16;

	// Field widths
	localparam int IDX_W     = 4;
	localparam int FRAC_W    = 32;
	localparam int SPIN_W    = 10;
	localparam int BOND_W    = 11;
	localparam int CFG_IDX_W = 1;

	// Request payload layout, lowest bit first
	localparam int ROW_LSB   = 0;
	localparam int COL_LSB   = 4;
	localparam int RND_LSB   = 8;
	localparam int IN_DATA_W = 40;

	// Result payload layout, lowest bit first
	localparam int OUT_FLIP_BIT = 0;
	localparam int OUT_SPIN_LSB = 1;
	localparam int OUT_BOND_LSB = 11;
	localparam int OUT_DATA_W   = 24;

	// Operation codes carried in tuser
	localparam logic OP_FLIP = 1'b0;
	localparam logic OP_FILL = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_DE4 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_DE8 = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_C,
		ST_RD_UP,
		ST_RD_DN,
		ST_EVAL,
		ST_COMMIT
	} state_t;

	// Which lattice row the read port fetches
	typedef enum logic [1:0] {
		RS_CTR,
		RS_UP,
		RS_DN
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_ctr;
		logic    cap_up;
		logic    eval;
		logic    commit;
	} cmd_t;

	typedef struct packed {
		logic in_fill;
		logic out_stall;
	} stat_t;

	// Spin sum of an all-up lattice, wrapped to the field width
	function automatic logic [SPIN_W-1:0] spin_rst(input int side);
		return SPIN_W'(side * side);
	endfunction

	// Bond sum of an all-up lattice, wrapped to the field width
	function automatic logic [BOND_W-1:0] bond_rst(input int side);
		return BOND_W'(2 * side * side);
	endfunction

endpackage

>>> hdl/imf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/imf_ctrl.sv
// Controller: sequences row reads, evaluation and commit of one request.
module imf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  imf_pkg::stat_t stat,
	output imf_pkg::cmd_t  cmd
);
	import imf_pkg::*;

	state_t state_q;
	state_t state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx    = state_q;
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.rd_sel  = RS_CTR;
		cmd.cap_ctr = 1'b0;
		cmd.cap_up  = 1'b0;
		cmd.eval    = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = stat.in_fill ? ST_COMMIT : ST_RD_C;
				end
			end
			ST_RD_C: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RS_CTR;
				state_nx   = ST_RD_UP;
			end
			ST_RD_UP: begin
				cmd.cap_ctr = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RS_UP;
				state_nx    = ST_RD_DN;
			end
			ST_RD_DN: begin
				cmd.cap_up = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RS_DN;
				state_nx   = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the result register is free
				if (!stat.out_stall) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/imf_dp.sv
// Datapath: site indexing, neighbor gather, Metropolis test, sums and result register.
module imf_dp #(
	parameter int SIDE = imf_pkg::SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [imf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imf_pkg::FRAC_W-1:0]      cfg_data,
	input  logic [imf_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [imf_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  imf_pkg::cmd_t                   cmd,
	output imf_pkg::stat_t                  stat,
	output logic                            ram_we,
	output logic [$clog2(SIDE)-1:0]         ram_waddr,
	output logic [SIDE-1:0]                 ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(SIDE)-1:0]         ram_raddr,
	input  logic [SIDE-1:0]                 ram_rdata
);
	import imf_pkg::*;

	localparam int AW = $clog2(SIDE);
	localparam logic [AW-1:0]     LAST     = AW'(SIDE - 1);
	localparam logic [SPIN_W-1:0] SPIN_RST = spin_rst(SIDE);
	localparam logic [BOND_W-1:0] BOND_RST = bond_rst(SIDE);

	// Reduce a 4-bit index modulo SIDE
	function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
		logic [8:0] m;
		m = {5'b0, v};
		for (int k = 0; k < 3; k++) begin
			if (m >= 9'(SIDE)) begin
				m = m - 9'(SIDE);
			end
		end
		return m[AW-1:0];
	endfunction

	logic [FRAC_W-1:0] acc4_q;
	logic [FRAC_W-1:0] acc8_q;
	logic              op_q;
	logic [AW-1:0]     r_q, c_q, up_q, dn_q, lf_q, rt_q;
	logic [FRAC_W-1:0] rnd_q;
	logic [AW-1:0]     r_nx, c_nx;
	logic [SIDE-1:0]   row_vld_q;
	logic              rd_vld_q;
	logic [SIDE-1:0]   row_live;
	logic [SIDE-1:0]   row_q;
	logic              up_bit_q;
	logic              s_bit;
	logic [2:0]        agree;
	logic              take_nx;
	logic              take_q;
	logic [2:0]        agree_q;
	logic              flip_do;
	logic [SPIN_W-1:0] spin_sum_q;
	logic [BOND_W-1:0] bond_sum_q;
	logic [SPIN_W-1:0] spin_nx;
	logic [BOND_W-1:0] bond_nx;
	logic              flipped_q;
	logic [SPIN_W-1:0] out_spin_q;
	logic [BOND_W-1:0] out_bond_q;
	logic              m_tvalid_q;

	// Acceptance registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc4_q <= '0;
			acc8_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCEPT_DE4: acc4_q <= cfg_data;
				CFG_ACCEPT_DE8: acc8_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign r_nx = wrap_idx(s_tdata[COL_LSB-1:ROW_LSB]);
	assign c_nx = wrap_idx(s_tdata[RND_LSB-1:COL_LSB]);

	// Latch the request and its wrapped neighbor indexes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tuser;
			r_q   <= r_nx;
			c_q   <= c_nx;
			up_q  <= (r_nx == '0)   ? LAST : r_nx - AW'(1);
			dn_q  <= (r_nx == LAST) ? '0   : r_nx + AW'(1);
			lf_q  <= (c_nx == '0)   ? LAST : c_nx - AW'(1);
			rt_q  <= (c_nx == LAST) ? '0   : c_nx + AW'(1);
			rnd_q <= s_tdata[IN_DATA_W-1:RND_LSB];
		end
	end

	// Read port address select
	always_comb begin
		case (cmd.rd_sel)
			RS_CTR:  ram_raddr = r_q;
			RS_UP:   ram_raddr = up_q;
			RS_DN:   ram_raddr = dn_q;
			default: ram_raddr = r_q;
		endcase
	end
	assign ram_re = cmd.rd_en;

	// Sample the row valid flag alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else if (cmd.rd_en) begin
			rd_vld_q <= row_vld_q[ram_raddr];
		end
	end

	// A row never written since reset or fill reads as all spins up
	assign row_live = ram_rdata & {SIDE{rd_vld_q}};

	// Gather the site row and the upper neighbor
	always_ff @(posedge clk) begin
		if (cmd.cap_ctr) begin
			row_q <= row_live;
		end
		if (cmd.cap_up) begin
			up_bit_q <= row_live[c_q];
		end
	end

	// Count neighbors aligned with the site spin; dE = 4*agree - 8
	assign s_bit = row_q[c_q];
	assign agree = {2'b0, ~(up_bit_q ^ s_bit)}
	             + {2'b0, ~(row_live[c_q] ^ s_bit)}
	             + {2'b0, ~(row_q[lf_q] ^ s_bit)}
	             + {2'b0, ~(row_q[rt_q] ^ s_bit)};

	assign take_nx = (agree <= 3'd2)
	               || ((agree == 3'd3) && (acc4_q >= rnd_q))
	               || ((agree == 3'd4) && (acc8_q >= rnd_q));

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			take_q  <= take_nx;
			agree_q <= agree;
		end
	end

	// Commit the flip: write the row back and update the sums
	assign flip_do   = (op_q == OP_FLIP) && take_q;
	assign ram_we    = cmd.commit && flip_do;
	assign ram_waddr = r_q;
	assign ram_wdata = row_q ^ (SIDE'(1) << c_q);

	assign spin_nx = s_bit ? spin_sum_q + SPIN_W'(2) : spin_sum_q - SPIN_W'(2);
	assign bond_nx = bond_sum_q + BOND_W'(8) - {{(BOND_W-5){1'b0}}, agree_q, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			spin_sum_q <= SPIN_RST;
			bond_sum_q <= BOND_RST;
		end else if (cmd.commit) begin
			if (op_q == OP_FILL) begin
				row_vld_q  <= '0;
				spin_sum_q <= SPIN_RST;
				bond_sum_q <= BOND_RST;
			end else if (take_q) begin
				row_vld_q[r_q] <= 1'b1;
				spin_sum_q     <= spin_nx;
				bond_sum_q     <= bond_nx;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			flipped_q <= flip_do;
			if (op_q == OP_FILL) begin
				out_spin_q <= SPIN_RST;
				out_bond_q <= BOND_RST;
			end else if (take_q) begin
				out_spin_q <= spin_nx;
				out_bond_q <= bond_nx;
			end else begin
				out_spin_q <= spin_sum_q;
				out_bond_q <= bond_sum_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-1-SPIN_W-BOND_W){1'b0}}, out_bond_q, out_spin_q, flipped_q};

	assign stat.in_fill   = (s_tuser == OP_FILL);
	assign stat.out_stall = m_tvalid_q && !m_tready;

endmodule

>>> hdl/ising_metropolis_flip.sv
// Top level of the two-dimensional Ising Metropolis spin-flip engine.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  tdata: row, col, rand_frac; tuser: op
//   m_*       out        m_tvalid / m_tready  tdata: flipped, spin_sum, bond_sum
//   cfg_*     in         cfg_we               cfg_index, cfg_data
//
// A flip request steps through accept, three row reads through the single
// lattice RAM read port (site row, row above, row below), evaluate, commit.
// A fill request steps through accept and commit.
// Reset and fill clear one valid flag per lattice row at once; a row without
// its flag reads as all spins up, so there is no clearing pass.
// A held result stalls only the commit of the following request.
module ising_metropolis_flip #(
	parameter int SIDE = imf_pkg::SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [imf_pkg::IN_DATA_W-1:0]  s_tdata,   // row[3:0], col[7:4], rand_frac[39:8]
	input  logic                           s_tuser,   // op[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [imf_pkg::OUT_DATA_W-1:0] m_tdata,   // flipped[0], spin_sum[10:1], bond_sum[21:11]
	input  logic                           cfg_we,
	input  logic [imf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imf_pkg::FRAC_W-1:0]     cfg_data
);
	import imf_pkg::*;

	localparam int AW = $clog2(SIDE);
	localparam logic [SPIN_W-1:0] SPIN_RST = spin_rst(SIDE);
	localparam logic [BOND_W-1:0] BOND_RST = bond_rst(SIDE);

	cmd_t            cmd;
	stat_t           stat;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [SIDE-1:0] ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [SIDE-1:0] ram_rdata;

	imf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	imf_dp #(
		.SIDE (SIDE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Lattice, one row per word
	imf_ram #(
		.WIDTH (SIDE),
		.DEPTH (SIDE)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef ASSERT_OFF
	// One request at a time: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while the previous one is in flight");

	// Flips move the spin sum by two, so its parity never changes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_SPIN_LSB] == SPIN_RST[0]))
		else $error("spin sum parity broken");

	// Flips move the bond sum by a multiple of four
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_BOND_LSB +: 2] == BOND_RST[1:0]))
		else $error("bond sum residue broken");
`endif

endmodule
